// File: rtl/core/wre_pkg.sv
`timescale 1ns / 1ps
package wre_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxRadius = 15;
  localparam int unsigned Cells     = MaxWidth * MaxHeight;
  localparam int unsigned AddrW     = $clog2(Cells);
  localparam int unsigned DimW      = $clog2(MaxWidth) + 1;
  localparam int unsigned HgtDimW   = $clog2(MaxHeight) + 1;
  localparam int unsigned RadW      = $clog2(MaxRadius + 1);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_DROP   = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_RENDER = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_DAMP   = 3'd2,
    CFG_RADIUS = 3'd3,
    CFG_DEPTH  = 3'd4
  } cfg_e;

  // Sequencer states. Map reads fetch one neighbor per cycle.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,      // issue neighbor/old reads, one per cycle
    ST_CALC,    // combine gathered values
    ST_WR,      // write update result
    ST_SRC,     // issue source read
    ST_SRCW,    // wait source read
    ST_OUT,     // hold result until taken
    ST_DROP     // sweep stamp window
  } state_e;

  // Read slot order for update/render gathering.
  typedef enum logic [2:0] {
    RD_LEFT  = 3'd0,
    RD_UP    = 3'd1,
    RD_RIGHT = 3'd2,
    RD_DOWN  = 3'd3,
    RD_OLD   = 3'd4
  } rd_e;

  function automatic logic signed [15:0] asr16(logic signed [15:0] v, logic [3:0] s);
    return v >>> s;
  endfunction
endpackage

// File: rtl/core/wre_hmap.sv
`timescale 1ns / 1ps
// Height map pair sharing one registered read port and one write port.
module wre_hmap
  import wre_pkg::*;
(
  input  logic                clk_i,
  input  logic                rd_sel_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic [15:0]         rd_data_o,
  input  logic                wr_en_i,
  input  logic                wr_sel_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic [15:0]         wr_data_i
);
  logic [15:0] mem_a [Cells];
  logic [15:0] mem_b [Cells];
  logic [15:0] a_q, b_q;
  logic        sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_sel_i) mem_a[wr_addr_i] <= wr_data_i;
    a_q <= mem_a[rd_addr_i];
  end
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_sel_i) mem_b[wr_addr_i] <= wr_data_i;
    b_q <= mem_b[rd_addr_i];
    sel_q <= rd_sel_i;
  end
  assign rd_data_o = sel_q ? b_q : a_q;
endmodule

// File: rtl/core/wre_src.sv
`timescale 1ns / 1ps
module wre_src
  import wre_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [31:0]      wr_data_i,
  output logic [31:0]      rd_data_o
);
  logic [31:0] mem [Cells];
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[addr_i] <= wr_data_i;
    rd_data_o <= mem[addr_i];
  end
endmodule

// File: rtl/core/water_ripple_engine_core.sv
`timescale 1ns / 1ps
// water_ripple_engine_core: 2-D water ripple on a stored image.
// Input channel (in_valid_i/in_ready_o) takes one request: load pixel,
// drop a disk, update one height cell, or render one pixel. Only render
// gives a transaction on the output channel (out_valid_o/out_ready_i).
// Config channel (cfg_valid_i/cfg_ready_o) writes registers by index;
// write only while the core is idle.
// Sequencing: a load leaves the core idle, so loads can follow back to
// back; an update gathers four neighbors and the old value (ST_RD),
// combines them (ST_CALC) and writes (ST_WR); a render gathers the same,
// reads the source (ST_SRC, ST_SRCW) and holds out_valid_o in ST_OUT;
// a drop sweeps its window, of side 2r+1, one cell per cycle, and a
// rejected drop leaves the core idle. All map reads go through one read
// port per map pair, one word per cycle.
// After reset both height maps are cleared by a pass that writes one
// cell of one map a cycle; in_ready_o stays low during it. A result
// waits in the output register while the receiver stalls, and no new
// item is taken until it leaves.
module water_ripple_engine_core
  import wre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] cell_index_i,
  input  logic [31:0] pixel_value_i,
  input  logic [7:0]  drop_x_i,
  input  logic [7:0]  drop_y_i,
  input  logic        end_of_pass_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] rendered_pixel_o,
  output logic [15:0] pixel_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  state_e state_q, state_d;
  logic [DimW-1:0]    width_q;
  logic [HgtDimW-1:0] height_q;
  logic [3:0]         damp_q, radius_q;
  logic [15:0]        depth_q;
  logic               cur_q;

  logic [1:0]  type_q;
  logic [15:0] idx_q;
  logic        eop_q;
  logic [7:0]  dx0_q, dy0_q;
  logic [2:0]  slot_q;
  logic [2:0]  cnt_q;
  logic signed [15:0] nb_q [4];
  logic signed [15:0] old_q;
  logic [AddrW:0] clr_q;
  logic [15:0]    res_q;
  logic [31:0]    pix_q;
  logic signed [5:0] sx_q, sy_q;
  logic [AddrW-1:0]  src_addr_q;
  logic              interior_q;

  // effective sizes
  logic [DimW-1:0] w_eff;
  logic [HgtDimW-1:0] h_eff;
  always_comb begin
    w_eff = width_q;
    if (width_q < DimW'(2)) w_eff = DimW'(2);
    if (width_q > DimW'(MaxWidth)) w_eff = DimW'(MaxWidth);
    h_eff = height_q;
    if (height_q < HgtDimW'(3)) h_eff = HgtDimW'(3);
    if (height_q > HgtDimW'(MaxHeight)) h_eff = HgtDimW'(MaxHeight);
  end
  logic [RadW-1:0] r_eff;
  assign r_eff = (radius_q > 4'(MaxRadius)) ? RadW'(MaxRadius) : RadW'(radius_q);

  logic [AddrW:0] cells, lo_lim, hi_lim;
  assign cells  = (AddrW+1)'(w_eff * h_eff);
  assign lo_lim = (AddrW+1)'(w_eff);
  assign hi_lim = (AddrW+1)'(w_eff * (h_eff - HgtDimW'(1)));

  logic acc_in, acc_out;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign acc_in  = in_valid_i && in_ready_o;
  assign acc_out = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(256);
      height_q <= HgtDimW'(256);
      damp_q   <= 4'd3;
      radius_q <= 4'd3;
      depth_q  <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= DimW'(cfg_data_i[8:0]);
        CFG_HEIGHT: height_q <= HgtDimW'(cfg_data_i[8:0]);
        CFG_DAMP:   damp_q   <= cfg_data_i[3:0];
        CFG_RADIUS: radius_q <= cfg_data_i[3:0];
        CFG_DEPTH:  depth_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // map read address
  logic [AddrW-1:0] hm_raddr;
  logic             hm_rsel;
  logic [15:0]      hm_rdata;
  always_comb begin
    hm_rsel = cur_q;
    unique case (rd_e'(slot_q))
      RD_LEFT:  hm_raddr = AddrW'(idx_q - 16'd1);
      RD_UP:    hm_raddr = AddrW'(idx_q - 16'(w_eff));
      RD_RIGHT: hm_raddr = AddrW'(idx_q + 16'd1);
      RD_DOWN:  hm_raddr = AddrW'(idx_q + 16'(w_eff));
      RD_OLD: begin
        hm_raddr = AddrW'(idx_q);
        hm_rsel  = ~cur_q;
      end
      default:  hm_raddr = AddrW'(idx_q);
    endcase
  end

  // update arithmetic
  logic signed [17:0] sum4;
  logic signed [15:0] n1, n2;
  always_comb begin
    sum4 = 18'(nb_q[0]) + 18'(nb_q[1]) + 18'(nb_q[2]) + 18'(nb_q[3]);
    n1 = 16'(sum4 >>> 1) - old_q;
    n2 = n1 - asr16(n1, damp_q);
  end

  // render target
  logic signed [AddrW+9:0] off, tgt;
  always_comb begin
    off = (AddrW+10)'($signed({1'b0, w_eff}) * (17'(nb_q[1]) - 17'(nb_q[3])))
        + (AddrW+10)'(17'(nb_q[0]) - 17'(nb_q[2]));
    tgt = (AddrW+10)'($signed({1'b0, idx_q})) + off;
  end

  // drop sweep
  logic signed [11:0] d2;
  logic in_disk;
  logic [15:0] drop_val;
  logic [AddrW-1:0] drop_addr;
  logic signed [9:0] px, py;
  always_comb begin
    d2 = 12'(sx_q * sx_q) + 12'(sy_q * sy_q);
    in_disk = d2 <= 12'(r_eff * r_eff);
    drop_val = (r_eff == RadW'(1)) ? depth_q - 16'(d2) : depth_q;
    px = $signed({2'b0, dx0_q}) + 10'(sx_q);
    py = $signed({2'b0, dy0_q}) + 10'(sy_q);
    drop_addr = AddrW'(py * $signed({1'b0, w_eff}) + px);
  end

  logic hm_we;
  logic hm_wsel;
  logic [AddrW-1:0] hm_waddr;
  logic [15:0] hm_wdata;
  always_comb begin
    hm_we = 1'b0; hm_wsel = ~cur_q; hm_waddr = AddrW'(idx_q); hm_wdata = res_q;
    unique case (state_q)
      ST_CLEAR: begin
        hm_we = 1'b1; hm_wsel = clr_q[0]; hm_waddr = clr_q[AddrW:1]; hm_wdata = '0;
      end
      ST_WR:   hm_we = interior_q;
      ST_DROP: begin
        hm_we = in_disk; hm_wsel = cur_q; hm_waddr = drop_addr; hm_wdata = drop_val;
      end
      default: ;
    endcase
  end

  wre_hmap u_hmap (
    .clk_i, .rd_sel_i(hm_rsel), .rd_addr_i(hm_raddr), .rd_data_o(hm_rdata),
    .wr_en_i(hm_we), .wr_sel_i(hm_wsel), .wr_addr_i(hm_waddr), .wr_data_i(hm_wdata)
  );

  logic src_we;
  logic [AddrW-1:0] src_addr;
  logic [31:0] src_rdata;
  assign src_we = acc_in && (req_e'(req_type_i) == REQ_LOAD);
  assign src_addr = src_we ? AddrW'(cell_index_i) : src_addr_q;
  wre_src u_src (
    .clk_i, .wr_en_i(src_we), .addr_i(src_addr), .wr_data_i(pixel_value_i),
    .rd_data_o(src_rdata)
  );

  logic clr_wrap;
  assign clr_wrap = (clr_q == (AddrW+1)'(2*Cells - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_wrap) state_d = ST_IDLE;
      ST_IDLE: if (acc_in) begin
        unique case (req_e'(req_type_i))
          REQ_LOAD:   state_d = ST_IDLE;
          REQ_DROP:   state_d = ST_DROP;
          REQ_UPDATE: state_d = ST_RD;
          REQ_RENDER: state_d = ST_RD;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_RD: if (cnt_q == 3'd5) state_d = ST_CALC;
      ST_CALC: state_d = (req_e'(type_q) == REQ_UPDATE) ? ST_WR : ST_SRC;
      ST_WR:   state_d = ST_IDLE;
      ST_SRC:  state_d = ST_SRCW;
      ST_SRCW: state_d = ST_OUT;
      ST_OUT:  if (acc_out) state_d = ST_IDLE;
      ST_DROP: if (sx_q == 6'(r_eff) && sy_q == 6'(r_eff)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic drop_ok;
  assign drop_ok = !((9'(drop_x_i) + 9'(r_eff) >= 9'(w_eff)) ||
                     (9'(drop_y_i) + 9'(r_eff) >= 9'(h_eff)) ||
                     (drop_x_i <= 8'(r_eff)) || (drop_y_i <= 8'(r_eff)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cur_q   <= 1'b0;
    end else begin
      state_q <= (state_q == ST_IDLE && acc_in && req_e'(req_type_i) == REQ_DROP
                  && !drop_ok) ? ST_IDLE : state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_WR && eop_q) cur_q <= ~cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      type_q <= req_type_i; idx_q <= cell_index_i; eop_q <= end_of_pass_i;
      dx0_q <= drop_x_i; dy0_q <= drop_y_i;
      sx_q <= -6'(r_eff); sy_q <= -6'(r_eff);
      slot_q <= 3'd0; cnt_q <= 3'd0;
      interior_q <= (17'(cell_index_i) >= lo_lim) && (17'(cell_index_i) < hi_lim);
    end
    if (state_q == ST_RD) begin
      if (slot_q != RD_OLD) slot_q <= slot_q + 3'd1;
      cnt_q <= cnt_q + 3'd1;
      // read data appears in the cycle after its address
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) nb_q[cnt_q[1:0] - 2'd1] <= hm_rdata;
      if (cnt_q == 3'd5) old_q <= hm_rdata;
    end
    if (state_q == ST_CALC) begin
      res_q <= n2;
      if (interior_q && tgt > 0 && tgt < $signed({1'b0, cells}))
        src_addr_q <= AddrW'(tgt);
      else src_addr_q <= AddrW'(idx_q);
    end
    if (state_q == ST_SRCW) pix_q <= src_rdata;
    if (state_q == ST_DROP) begin
      if (sx_q == 6'(r_eff)) begin
        sx_q <= -6'(r_eff); sy_q <= sy_q + 6'd1;
      end else sx_q <= sx_q + 6'd1;
    end
  end

  assign out_valid_o      = (state_q == ST_OUT);
  assign rendered_pixel_o = pix_q;
  assign pixel_index_o    = idx_q;

  a_out_only_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> req_e'(type_q) == REQ_RENDER) else $error("output without render");
  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  a_swap_only_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> $past(state_q) == ST_WR) else $error("stray swap");
endmodule

// File: bench/tb_water_ripple_engine_core.sv
`timescale 1ns / 1ps
module tb_water_ripple_engine_core;
  import wre_pkg::*;

  localparam logic [2:0] CfgUnused = 3'd7;
  localparam int Settle = 1000;  // longest no-result item: a radius-15 drop window

  typedef struct packed {
    logic [31:0] pixel;
    logic [15:0] index;
  } render_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_e        req_type = REQ_LOAD;
  logic [15:0] cell_index = '0;
  logic [31:0] pixel_value = '0;
  logic [7:0]  drop_x = '0;
  logic [7:0]  drop_y = '0;
  logic        end_of_pass = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] rendered_pixel;
  logic [15:0] pixel_index;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor state
  logic [31:0] src_img [Cells];
  bit          src_loaded [Cells];
  logic [15:0] hgt [2][Cells];
  bit          cur_sel;
  logic [8:0]  reg_width, reg_height;
  logic [3:0]  reg_damp, reg_radius;
  logic [15:0] reg_depth;

  render_t render_q[$];
  int n_err;
  int n_items;
  int snd_idle_pct, rcv_stall_pct;
  int hold_off;

  water_ripple_engine_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .cell_index_i    (cell_index),
    .pixel_value_i   (pixel_value),
    .drop_x_i        (drop_x),
    .drop_y_i        (drop_y),
    .end_of_pass_i   (end_of_pass),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .rendered_pixel_o(rendered_pixel),
    .pixel_index_o   (pixel_index),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #120_000_000;
    $display("water_ripple_engine_core verification failed");
    $finish;
  end

  function automatic int eff_w();
    if (reg_width < 2) return 2;
    if (reg_width > MaxWidth) return MaxWidth;
    return int'(reg_width);
  endfunction

  function automatic int eff_h();
    if (reg_height < 3) return 3;
    if (reg_height > MaxHeight) return MaxHeight;
    return int'(reg_height);
  endfunction

  function automatic int sh(int i);
    return int'($signed(hgt[cur_sel][i]));
  endfunction

  // Source address a render at idx will read
  function automatic int displaced_addr(int idx);
    int w, h, t;
    w = eff_w();
    h = eff_h();
    if (idx >= w && idx < w * (h - 1)) begin
      t = idx + w * (sh(idx - w) - sh(idx + w)) + (sh(idx - 1) - sh(idx + 1));
      if (t > 0 && t < w * h) return t;
    end
    return idx;
  endfunction

  task automatic predict_stamp(int x, int y);
    int w, h, r, d2, rate;
    w = eff_w();
    h = eff_h();
    r = int'(reg_radius);
    if (r > MaxRadius) r = MaxRadius;
    if (x + r >= w || y + r >= h || x <= r || y <= r) return;
    rate = (r == 1) ? 1 : 0;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        d2 = dx * dx + dy * dy;
        if (d2 <= r * r)
          hgt[cur_sel][(y + dy) * w + x + dx] = 16'(int'($signed(reg_depth)) - d2 * rate);
      end
    end
  endtask

  task automatic predict_wave(int idx, bit eop);
    int w, h, s;
    logic signed [15:0] n;
    w = eff_w();
    h = eff_h();
    if (idx >= w && idx < w * (h - 1)) begin
      s = sh(idx - 1) + sh(idx - w) + sh(idx + 1) + sh(idx + w);
      n = 16'((s >>> 1) - int'($signed(hgt[!cur_sel][idx])));
      n = n - (n >>> reg_damp);
      hgt[!cur_sel][idx] = n;
    end
    if (eop) cur_sel = !cur_sel;
  endtask

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    n_err++;
  endtask

  // Send one transaction and apply it to the predictor once accepted
  task automatic send_req(req_e t, int idx, logic [31:0] pix, int x, int y, bit eop);
    bit rdy;
    render_t r;
    idx = idx & 32'hFFFF;
    x = x & 32'hFF;
    y = y & 32'hFF;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid    <= 1'b1;
    req_type    <= t;
    cell_index  <= 16'(idx);
    pixel_value <= pix;
    drop_x      <= 8'(x);
    drop_y      <= 8'(y);
    end_of_pass <= eop;
    do begin
      @(negedge clk_i);
      rdy = in_ready;
      @(posedge clk_i);
    end while (!rdy);
    n_items++;
    case (t)
      REQ_LOAD: begin
        src_img[idx] = pix;
        src_loaded[idx] = 1'b1;
      end
      REQ_DROP:   predict_stamp(x, y);
      REQ_UPDATE: predict_wave(idx, eop);
      default: begin
        r.index = 16'(idx);
        r.pixel = src_img[displaced_addr(idx)];
        render_q.push_back(r);
      end
    endcase
  endtask

  // Keep every source read on a loaded pixel
  task automatic render_at(int idx);
    int a;
    a = displaced_addr(idx & 32'hFFFF);
    if (!src_loaded[a]) send_req(REQ_LOAD, a, $urandom, $urandom, $urandom, 1'($urandom));
    send_req(REQ_RENDER, idx, $urandom, $urandom, $urandom, 1'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (render_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, int value, int width);
    bit rdy;
    logic [15:0] d;
    d = 16'($urandom);
    for (int b = 0; b < width; b++) d[b] = value[b];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:  reg_width  = d[8:0];
      CFG_HEIGHT: reg_height = d[8:0];
      CFG_DAMP:   reg_damp   = d[3:0];
      CFG_RADIUS: reg_radius = d[3:0];
      CFG_DEPTH:  reg_depth  = d;
      default: ;
    endcase
  endtask

  task automatic set_mode(int w, int h, int damp, int rad, int depth);
    wait_idle();
    cfg_write(CFG_WIDTH, w, 9);
    cfg_write(CFG_HEIGHT, h, 9);
    cfg_write(CFG_DAMP, damp, 4);
    cfg_write(CFG_RADIUS, rad, 4);
    cfg_write(CFG_DEPTH, depth, 16);
  endtask

  task automatic rand_items(int n);
    int w, h, cells, last, idx, sel;
    w = eff_w();
    h = eff_h();
    cells = w * h;
    last = n_items + n;
    while (n_items < last) begin
      sel = $urandom_range(99);
      idx = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(cells - 1);
      if (sel < 8 && cells <= 600) begin
        for (int i = w; i < w * (h - 1); i++)
          send_req(REQ_UPDATE, i, $urandom, $urandom, $urandom, i == w * (h - 1) - 1);
      end else if (sel < 20) begin
        if ($urandom_range(6) == 0)
          send_req(REQ_DROP, idx, $urandom, $urandom_range(255), $urandom_range(255),
                   1'($urandom));
        else
          send_req(REQ_DROP, idx, $urandom, $urandom_range(w - 1), $urandom_range(h - 1),
                   1'($urandom));
      end else if (sel < 35) begin
        send_req(REQ_LOAD, idx, $urandom, $urandom, $urandom, 1'($urandom));
      end else if (sel < 60) begin
        send_req(REQ_UPDATE, idx, $urandom, $urandom, $urandom, $urandom_range(19) == 0);
      end else begin
        render_at(idx);
      end
    end
  endtask

  task automatic test_directed();
    set_mode(16, 8, 3, 3, 256);
    send_req(REQ_LOAD, 0, 32'h0, 0, 0, 0);
    send_req(REQ_LOAD, 65535, 32'hFFFF_FFFF, 255, 255, 1);
    render_at(0);
    render_at(65535);
    send_req(REQ_DROP, 0, 0, 3, 4, 0);       // left edge rejected
    send_req(REQ_DROP, 0, 0, 13, 4, 0);      // right edge rejected
    send_req(REQ_DROP, 0, 0, 6, 3, 0);       // top edge rejected
    send_req(REQ_DROP, 0, 0, 6, 5, 0);       // bottom edge rejected
    send_req(REQ_DROP, 0, 0, 255, 255, 0);
    send_req(REQ_DROP, 0, 0, 7, 4, 0);
    send_req(REQ_UPDATE, 5, 0, 0, 0, 1);     // outside interior, still swaps
    send_req(REQ_UPDATE, 40, 0, 0, 0, 0);
    send_req(REQ_UPDATE, 120, 0, 0, 0, 1);
    render_at(71);
    render_at(20);
    render_at(127);
    set_mode(16, 8, 0, 1, -32768);
    send_req(REQ_DROP, 0, 0, 2, 2, 0);
    render_at(33);
    wait_idle();
    cfg_write(CFG_RADIUS, 0, 4);
    send_req(REQ_DROP, 0, 0, 1, 1, 0);
    send_req(REQ_DROP, 0, 0, 0, 1, 0);
    wait_idle();
    cfg_write(CFG_DEPTH, 32767, 16);
    cfg_write(CFG_RADIUS, 15, 4);
    cfg_write(CfgUnused, 0, 16);
    render_at(17);
  endtask

  task automatic test_settings();
    int modes [4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{18, 18}};
    int cfgs [6][5] = '{'{8, 6, 0, 1, 40}, '{2, 3, 15, 0, -32768}, '{256, 256, 3, 15, 32767},
                        '{12, 10, 1, 2, 5}, '{0, 1, 15, 1, 3}, '{511, 511, 2, 3, 256}};
    for (int p = 0; p < 6; p++) begin
      set_mode(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4]);
      for (int m = 0; m < 4; m++) begin
        snd_idle_pct  = modes[m][0];
        rcv_stall_pct = modes[m][1];
        rand_items(60);
      end
    end
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_mode(10, 8, 2, 1, 7);
    hold_off = 3000;
    for (int i = 0; i < 40; i++) render_at($urandom_range(79));
    wait_idle();
    rand_items(60);
  endtask

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    render_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (render_q.size() == 0) begin
        report("unexpected render", {rendered_pixel, pixel_index}, '0);
      end else begin
        want = render_q.pop_front();
        if (rendered_pixel !== want.pixel)
          report("rendered_pixel", 48'(rendered_pixel), 48'(want.pixel));
        if (pixel_index !== want.index)
          report("pixel_index", 48'(pixel_index), 48'(want.index));
      end
    end
  end

  initial begin
    foreach (src_loaded[i]) src_loaded[i] = 1'b0;
    foreach (hgt[m, i]) hgt[m][i] = '0;
    cur_sel = 1'b0;
    reg_width = 256;
    reg_height = 256;
    reg_damp = 3;
    reg_radius = 3;
    reg_depth = 256;
    n_err = 0;
    n_items = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_off = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_backpressure();
    wait_idle();
    if (n_err == 0) begin
      $display("water_ripple_engine_core verification clean");
    end else begin
      $display("water_ripple_engine_core verification failed");
    end
    $finish;
  end
endmodule

// File: water_ripple_engine_core.f
rtl/core/wre_pkg.sv
rtl/core/wre_hmap.sv
rtl/core/wre_src.sv
rtl/core/water_ripple_engine_core.sv
bench/tb_water_ripple_engine_core.sv
